// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPA_ASSERT(label, clk, rst, prop, msg)
`define RPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/core/rpa_pkg.sv -----
// Shared widths, codes and defaults of the page allocator.
package rpa_pkg;

   localparam int NUM_PAGES_DEF  = 4096;
   localparam int PAGE_BYTES_DEF = 4096;

   localparam int ACT_W    = 2;
   localparam int ADDR_W   = 25;
   localparam int ADD_W    = 8;
   localparam int CFG_W    = 12;
   localparam int STATUS_W = 3;
   localparam int ALLOC_W  = 24;
   localparam int COUNT_W  = 16;

   typedef logic [ACT_W-1:0]    action_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam action_type ACT_ALLOC = 2'd0;
   localparam action_type ACT_FREE  = 2'd1;
   localparam action_type ACT_ADD   = 2'd2;
   localparam action_type ACT_READ  = 2'd3;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_NO_PAGES  = 3'd1;
   localparam status_type ST_BAD_ADDR  = 3'd2;
   localparam status_type ST_LIST_FULL = 3'd3;
   localparam status_type ST_SATURATED = 3'd4;

   localparam count_type COUNT_MAX = 16'hFFFF;

endpackage

// ----- rtl/core/refcounted_page_allocator.sv -----
// Top level: reference-counted page allocator with a LIFO free stack.
// Sequence: accept, count RAM read, then update and result load in S_REF; an
// allocate that pops the free stack reads the stack first (S_STK). rsp_stall can
// hold the word in S_REF. One word is in flight at a time: req_stall stays high
// through the read-modify-write of the count RAM.
// Reset: a clear sweep zeroes every count RAM entry, req_stall held high.
`include "assert_macros.svh"

module refcounted_page_allocator #(
   parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
   parameter int PAGE_BYTES = rpa_pkg::PAGE_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_write_en,
   input  logic [rpa_pkg::CFG_W-1:0]    csr_write_data,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rpa_pkg::ACT_W-1:0]    req_action,
   input  logic [rpa_pkg::ADDR_W-1:0]   req_page_addr,
   input  logic [rpa_pkg::ADD_W-1:0]    req_add_count,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [rpa_pkg::ALLOC_W-1:0]  rsp_alloc_addr,
   output logic [rpa_pkg::COUNT_W-1:0]  rsp_ref_value
);

   import rpa_pkg::*;

   // page index, stack depth / fresh counter, and page offset widths
   localparam int PG_W   = $clog2(NUM_PAGES);
   localparam int CNT_W  = $clog2(NUM_PAGES + 1);
   localparam int OFF_W  = $clog2(PAGE_BYTES);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int WIDE_W = ALLOC_W + PG_W + OFF_W;

   localparam logic [CNT_W-1:0]  ONE_C     = CNT_W'(1);
   localparam logic [CNT_W-1:0]  DEPTH_MAX = CNT_W'(NUM_PAGES);
   localparam logic [CNT_W-1:0]  TOP_PAGE  = CNT_W'(NUM_PAGES - 1);
   localparam logic [PG_W-1:0]   LAST_IDX  = PG_W'(NUM_PAGES - 1);
   localparam logic [ADDR_W-1:0] PAGES_A   = ADDR_W'(NUM_PAGES);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_STK  = 2'd1;  // stack RAM read in flight
   localparam logic [1:0] S_REF  = 2'd2;  // count RAM data valid, update

   // control state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] free_depth_ff, free_depth_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [CFG_W-1:0] first_page_ff;
   logic             clearing_ff;
   logic [PG_W-1:0]  clr_ff;
   logic             rsp_valid_ff;

   // per-word context
   action_type       op_ff, op_in;
   logic [PG_W-1:0]  pg_ff, pg_in;
   status_type       err_ff, err_in;
   logic [ADD_W-1:0] add_ff, add_in;

   // result register
   status_type          rsp_status_ff, rsp_status_in;
   logic [ALLOC_W-1:0]  rsp_addr_ff, rsp_addr_in;
   count_type           rsp_ref_ff, rsp_ref_in;

   // RAM ports
   logic            ref_we, ref_re;
   logic [PG_W-1:0] ref_waddr, ref_raddr;
   count_type       ref_wdata, ref_rdata;
   logic            stk_we, stk_re;
   logic [PG_W-1:0] stk_waddr, stk_raddr, stk_rdata;

   // request decode
   logic              req_acc;
   logic [ADDR_W-1:0] pg_full;
   logic              in_range, aligned, above_first;
   logic [CNT_W-1:0]  depth_m1, fresh_idx;
   logic              fresh_ok;

   // update stage
   logic               fire;
   logic               rej_wait;
   logic [COUNT_W:0]   add_sum;
   count_type          new_cnt;
   status_type         upd_status;
   logic               upd_write, upd_push;
   logic [WIDE_W-1:0]  addr_wide;

   assign req_stall = (state_ff != S_IDLE) || clearing_ff;
   assign req_acc   = req_valid && !req_stall;

   assign pg_full     = req_page_addr >> OFF_W;
   assign in_range    = pg_full < PAGES_A;
   assign aligned     = req_page_addr[OFF_W-1:0] == '0;
   assign above_first = pg_full >= ADDR_W'(first_page_ff);

   assign depth_m1  = free_depth_ff - ONE_C;
   assign fresh_idx = TOP_PAGE - fresh_ff;
   // fresh pages go top down and stop at first_page_ff
   assign fresh_ok  = (fresh_ff < DEPTH_MAX) && (CMP_W'(fresh_idx) >= CMP_W'(first_page_ff));

   // the result register takes a new word once its old one has left
   assign fire = (state_ff == S_REF) && !(rsp_valid_ff && rsp_stall);

   // rejected word waiting in the update stage
   assign rej_wait = (state_ff == S_REF) && (err_ff != ST_OK) && !clearing_ff;

   assign add_sum   = {1'b0, ref_rdata} + (COUNT_W + 1)'(add_ff);
   assign addr_wide = {{ALLOC_W{1'b0}}, pg_ff, {OFF_W{1'b0}}};

   // count update for the word in S_REF
   always_comb begin
      new_cnt    = ref_rdata;
      upd_status = ST_OK;
      upd_write  = 1'b0;
      upd_push   = 1'b0;
      case (op_ff)
         ACT_ALLOC: begin
            upd_write = 1'b1;
            if (ref_rdata == COUNT_MAX) begin
               upd_status = ST_SATURATED;
            end else begin
               new_cnt = ref_rdata + COUNT_W'(1);
            end
         end
         ACT_FREE: begin
            upd_write = 1'b1;
            if (ref_rdata > COUNT_W'(1)) begin
               new_cnt = ref_rdata - COUNT_W'(1);
            end else begin
               // final free: count cleared even if the stack is full
               new_cnt = '0;
               if (free_depth_ff >= DEPTH_MAX) begin
                  upd_status = ST_LIST_FULL;
               end else begin
                  upd_push = 1'b1;
               end
            end
         end
         ACT_ADD: begin
            upd_write = 1'b1;
            if (add_sum > (COUNT_W + 1)'(COUNT_MAX)) begin
               new_cnt    = COUNT_MAX;
               upd_status = ST_SATURATED;
            end else begin
               new_cnt = add_sum[COUNT_W-1:0];
            end
         end
         ACT_READ: begin
            upd_write = 1'b0;
         end
         default: begin
            upd_write = 1'b0;
         end
      endcase
   end

   // sequencer and RAM port control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pg_in         = pg_ff;
      err_in        = err_ff;
      add_in        = add_ff;
      free_depth_in = free_depth_ff;
      fresh_in      = fresh_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_ref_in    = rsp_ref_ff;
      ref_re        = 1'b0;
      ref_raddr     = pg_full[PG_W-1:0];
      ref_we        = 1'b0;
      ref_waddr     = pg_ff;
      ref_wdata     = new_cnt;
      stk_re        = 1'b0;
      stk_raddr     = depth_m1[PG_W-1:0];
      stk_we        = 1'b0;
      stk_waddr     = free_depth_ff[PG_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in    = req_action;
               add_in   = req_add_count;
               pg_in    = pg_full[PG_W-1:0];
               err_in   = ST_OK;
               state_in = S_REF;
               case (req_action)
                  ACT_ALLOC: begin
                     if (free_depth_ff != '0) begin
                        // pop: stack read first, count read next cycle
                        free_depth_in = depth_m1;
                        stk_re        = 1'b1;
                        state_in      = S_STK;
                     end else if (fresh_ok) begin
                        pg_in     = fresh_idx[PG_W-1:0];
                        fresh_in  = fresh_ff + ONE_C;
                        ref_re    = 1'b1;
                        ref_raddr = fresh_idx[PG_W-1:0];
                     end else begin
                        err_in = ST_NO_PAGES;
                     end
                  end
                  ACT_FREE: begin
                     if (aligned && in_range && above_first) begin
                        ref_re = 1'b1;
                     end else begin
                        err_in = ST_BAD_ADDR;
                     end
                  end
                  ACT_ADD, ACT_READ: begin
                     if (in_range) begin
                        ref_re = 1'b1;
                     end else begin
                        err_in = ST_BAD_ADDR;
                     end
                  end
                  default: begin
                     err_in = ST_BAD_ADDR;
                  end
               endcase
            end
         end
         S_STK: begin
            pg_in     = stk_rdata;
            ref_re    = 1'b1;
            ref_raddr = stk_rdata;
            state_in  = S_REF;
         end
         S_REF: begin
            if (fire) begin
               state_in = S_IDLE;
               if (err_ff != ST_OK) begin
                  rsp_status_in = err_ff;
                  rsp_addr_in   = '0;
                  rsp_ref_in    = '0;
               end else begin
                  rsp_status_in = upd_status;
                  rsp_addr_in   = (op_ff == ACT_ALLOC) ? addr_wide[ALLOC_W-1:0] : '0;
                  rsp_ref_in    = new_cnt;
                  ref_we        = upd_write;
                  if (upd_push) begin
                     stk_we        = 1'b1;
                     free_depth_in = free_depth_ff + ONE_C;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // post-reset sweep owns the count write port
      if (clearing_ff) begin
         ref_we    = 1'b1;
         ref_waddr = clr_ff;
         ref_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_depth_ff <= '0;
         fresh_ff      <= '0;
         first_page_ff <= '0;
         clearing_ff   <= 1'b1;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_depth_ff <= free_depth_in;
         fresh_ff      <= fresh_in;
         if (csr_write_en) begin
            first_page_ff <= csr_write_data;
         end
         if (clearing_ff) begin
            if (clr_ff == LAST_IDX) begin
               clearing_ff <= 1'b0;
            end else begin
               clr_ff <= clr_ff + PG_W'(1);
            end
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pg_ff         <= pg_in;
      err_ff        <= err_in;
      add_ff        <= add_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_ref_ff    <= rsp_ref_in;
   end

   // reference counts, cleared by the sweep
   rpa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (COUNT_W)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (ref_wdata),
      .rd_en   (ref_re),
      .rd_addr (ref_raddr),
      .rd_data (ref_rdata)
   );

   // free stack, only entries below the depth are ever read
   rpa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (PG_W)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (pg_ff),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_alloc_addr = rsp_addr_ff;
   assign rsp_ref_value  = rsp_ref_ff;

   `RPA_ASSERT(a_depth_bound, clock, reset, free_depth_ff <= DEPTH_MAX, "stack depth overflow")
   `RPA_ASSERT(a_accept_busy, clock, reset, req_acc |=> (state_ff != S_IDLE), "accept left idle")
   `RPA_ASSERT(a_clear_blocks, clock, reset, clearing_ff |-> req_stall, "accept during clear")
   `RPA_ASSERT(a_err_no_write, clock, reset, rej_wait |-> !(ref_we || stk_we), "reject wrote")
   `RPA_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (clearing_ff && !rsp_valid), "no clear")

endmodule

// ----- rtl/core/rpa_ram.sv -----
// Single-port-write, single-port-read synchronous RAM, registered read data.
module rpa_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/refcounted_page_allocator_test.sv -----
// Self-checking testbench for the reference-counted page allocator.
`timescale 1ns / 100ps

import rpa_pkg::*;

// Tracks the page pool as the block should see it and holds the result words
// still owed by the block, oldest first.
class page_pool_tracker;

   typedef struct packed {
      status_type          status;
      logic [ALLOC_W-1:0]  alloc_addr;
      count_type           ref_value;
   } alloc_result_type;

   logic [CFG_W-1:0]  stack_pages [NUM_PAGES_DEF];
   logic [12:0]       stack_depth;
   logic [12:0]       fresh_count;
   count_type         page_refs [NUM_PAGES_DEF];
   logic [CFG_W-1:0]  first_usable;
   alloc_result_type  pending_results [$];
   int unsigned       held_pages [$];
   int                mismatch_count;

   function new();
      foreach (page_refs[i]) begin
         page_refs[i] = '0;
         stack_pages[i] = '0;
      end
      stack_depth = '0;
      fresh_count = '0;
      first_usable = '0;
      mismatch_count = 0;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   function void set_first_usable(logic [CFG_W-1:0] value);
      first_usable = value;
   endfunction

   function void take_request(action_type act, logic [ADDR_W-1:0] addr,
                              logic [ADD_W-1:0] addn);
      alloc_result_type res;
      int unsigned      pg;
      int               top;
      logic [16:0]      sum;
      res = '0;
      pg = addr / PAGE_BYTES_DEF;
      case (act)
         ACT_ALLOC: begin
            top = NUM_PAGES_DEF - 1 - int'(fresh_count);
            if (stack_depth != 0) begin
               stack_depth = stack_depth - 1'b1;
               pg = stack_pages[stack_depth];
            end else if (top >= 0 && top >= int'(first_usable)) begin
               pg = top;
               fresh_count = fresh_count + 1'b1;
            end else begin
               res.status = ST_NO_PAGES;
               pending_results.push_back(res);
               return;
            end
            if (page_refs[pg] == COUNT_MAX) res.status = ST_SATURATED;
            else page_refs[pg] = page_refs[pg] + 1'b1;
            res.alloc_addr = ALLOC_W'(pg * PAGE_BYTES_DEF);
            res.ref_value = page_refs[pg];
            held_pages.push_back(pg);
         end
         ACT_FREE: begin
            if ((addr % PAGE_BYTES_DEF) != 0 || pg >= NUM_PAGES_DEF ||
                pg < first_usable) begin
               res.status = ST_BAD_ADDR;
            end else if (page_refs[pg] > 1) begin
               page_refs[pg] = page_refs[pg] - 1'b1;
               res.ref_value = page_refs[pg];
            end else begin
               page_refs[pg] = '0;
               if (stack_depth >= NUM_PAGES_DEF) begin
                  res.status = ST_LIST_FULL;
               end else begin
                  stack_pages[stack_depth] = CFG_W'(pg);
                  stack_depth = stack_depth + 1'b1;
               end
            end
         end
         default: begin
            if (pg >= NUM_PAGES_DEF) begin
               res.status = ST_BAD_ADDR;
            end else begin
               if (act == ACT_ADD) begin
                  sum = {1'b0, page_refs[pg]} + addn;
                  if (sum > COUNT_MAX) begin
                     page_refs[pg] = COUNT_MAX;
                     res.status = ST_SATURATED;
                  end else begin
                     page_refs[pg] = sum[COUNT_W-1:0];
                  end
               end
               res.ref_value = page_refs[pg];
            end
         end
      endcase
      pending_results.push_back(res);
   endfunction

   function void match_response(status_type st, logic [ALLOC_W-1:0] aa, count_type rv);
      alloc_result_type want;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected word: status %0d alloc_addr %h ref_value %0d",
                  $time, st, aa, rv);
         mismatch_count++;
         return;
      end
      want = pending_results.pop_front();
      if (st !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, st);
         mismatch_count++;
      end
      if (aa !== want.alloc_addr) begin
         $display("%0t: alloc_addr expected %h actual %h", $time, want.alloc_addr, aa);
         mismatch_count++;
      end
      if (rv !== want.ref_value) begin
         $display("%0t: ref_value expected %0d actual %0d", $time, want.ref_value, rv);
         mismatch_count++;
      end
   endfunction

endclass

module refcounted_page_allocator_test;

   // page that is driven to saturation and then handed out
   localparam int unsigned SAT_PAGE = 10;
   // length of the receiver's long hold-off, in cycles
   localparam int HOLD_CYCLES = 500;
   // well above the slowest passing run, including the clear sweep
   localparam longint TIMEOUT_NS = 64'd9_600_000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_en;
   logic [CFG_W-1:0]   csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [ACT_W-1:0]   req_action;
   logic [ADDR_W-1:0]  req_page_addr;
   logic [ADD_W-1:0]   req_add_count;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [ALLOC_W-1:0] rsp_alloc_addr;
   logic [COUNT_W-1:0] rsp_ref_value;

   page_pool_tracker pool;
   int               burst_left = 0;
   bit               stall_hold_request = 1'b0;

   refcounted_page_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_page_addr  (req_page_addr),
      .req_add_count  (req_add_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_alloc_addr (rsp_alloc_addr),
      .rsp_ref_value  (rsp_ref_value)
   );

   always #6 clock = ~clock;

   // Hard stop in case the block hangs or loses a word.
   initial begin
      #(TIMEOUT_NS);
      $display("** refcounted_page_allocator: FAILED **");
      $finish;
   end

   // Byte offset of a page, at the request field's width.
   function automatic logic [ADDR_W-1:0] page_base(int unsigned pg);
      return ADDR_W'(pg * PAGE_BYTES_DEF);
   endfunction

   // Offer one word at the falling edge and hold it until a rising edge
   // takes it (valid high, stall low). The tracker is told at that edge.
   task automatic push_word(action_type act, logic [ADDR_W-1:0] addr,
                            logic [ADD_W-1:0] addn);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= act;
      req_page_addr <= addr;
      req_add_count <= addn;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pool.take_request(act, addr, addn);
   endtask

   // Same, but in bursts of random length with random idle gaps between them.
   task automatic send_paced(action_type act, logic [ADDR_W-1:0] addr,
                             logic [ADD_W-1:0] addn);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      push_word(act, addr, addn);
   endtask

   // Drop valid and wait until every owed word has come back.
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pool.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_first_usable(logic [CFG_W-1:0] value);
      drain_pipeline();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      pool.set_first_usable(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Random word: mostly alloc/free traffic on pages actually handed out,
   // add counts that are often small so that pages drain back to the stack, plus noise.
   task automatic random_word(output action_type act, output logic [ADDR_W-1:0] addr,
                              output logic [ADD_W-1:0] addn);
      int unsigned roll;
      int unsigned pg;
      int          idx;
      roll = $urandom_range(0, 99);
      addr = ADDR_W'($urandom);
      addn = ADD_W'($urandom);
      idx  = -1;
      if (pool.held_pages.size() != 0) begin
         idx = $urandom_range(0, pool.held_pages.size() - 1);
         pg  = pool.held_pages[idx];
      end else begin
         pg = $urandom_range(pool.first_usable, NUM_PAGES_DEF - 1);
      end
      if (roll < 28) begin
         act = ACT_ALLOC;
      end else if (roll < 50) begin
         act  = ACT_FREE;
         addr = page_base(pg);
         if (idx >= 0) pool.held_pages.delete(idx);
      end else if (roll < 55) begin
         // free of an arbitrary usable page, often a double free
         act  = ACT_FREE;
         addr = page_base($urandom_range(pool.first_usable, NUM_PAGES_DEF - 1));
      end else if (roll < 68) begin
         act  = ACT_ADD;
         addr = page_base(pg) | ADDR_W'($urandom_range(0, 1) ? $urandom_range(0, 4095) : 0);
         if (roll < 62) addn = ADD_W'($urandom_range(0, 3));
      end else if (roll < 80) begin
         act  = ACT_READ;
         addr = page_base(pg) | ADDR_W'($urandom_range(0, 4095));
      end else begin
         act = action_type'($urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0: addr = page_base(pg) | ADDR_W'($urandom_range(1, 4095));  // misaligned
            1: addr[ADDR_W-1] = 1'b1;                                   // past the end
            default: ;                                                  // fully random
         endcase
      end
   endtask

   // Receiver: random stall pattern of its own, plus one long hold-off on
   // request so the block backs up and stalls its input.
   initial begin
      int unsigned run_left;
      int unsigned mode;
      rsp_stall = 1'b0;
      run_left = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (stall_hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_hold_request = 1'b0;
         end else begin
            if (run_left == 0) begin
               mode = $urandom_range(0, 3);
               run_left = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(5, 60);
            end
            run_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= $urandom_range(0, 1);
               2: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // Every word taken on the result side is checked against the oldest one owed.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         pool.match_response(rsp_status, rsp_alloc_addr, rsp_ref_value);
   end

   initial begin
      action_type          act;
      logic [ADDR_W-1:0]   addr;
      logic [ADD_W-1:0]    addn;
      logic [CFG_W-1:0]    fup;
      pool = new();
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_valid      = 1'b0;
      req_action     = ACT_READ;
      req_page_addr  = '0;
      req_add_count  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // the block clears its count RAM after reset with the input stalled
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);

      // ---- directed: field extremes, every action, each corner case ----
      write_first_usable('0);
      send_paced(ACT_READ, '0, '0);
      send_paced(ACT_READ, '1, '1);                       // page past the end
      send_paced(ACT_ADD, {1'b1, 24'h0}, 8'hFF);          // page past the end
      send_paced(ACT_ADD, 25'h0000FFF, 8'hFF);            // rounds down to page 0
      send_paced(ACT_ADD, '0, '0);
      send_paced(ACT_FREE, 25'h0000001, '0);              // misaligned
      send_paced(ACT_FREE, {1'b1, 24'h0}, '0);            // beyond the last page
      send_paced(ACT_ALLOC, '0, '0);                      // fresh page from the top

      // only the top page is usable now
      write_first_usable('1);
      send_paced(ACT_ALLOC, '0, '0);                      // out of pages
      send_paced(ACT_FREE, page_base(NUM_PAGES_DEF - 2), '0);  // below first usable
      send_paced(ACT_ADD, page_base(NUM_PAGES_DEF - 1), 8'd1);
      send_paced(ACT_FREE, page_base(NUM_PAGES_DEF - 1), '0);  // decrement only
      send_paced(ACT_FREE, page_base(NUM_PAGES_DEF - 1), '0);  // final free, pushed
      send_paced(ACT_FREE, page_base(NUM_PAGES_DEF - 1), '0);  // double free
      send_paced(ACT_ALLOC, '0, '0);                      // pops it
      send_paced(ACT_ALLOC, '0, '0);                      // pops the same page again
      send_paced(ACT_ALLOC, '0, '0);                      // empty again
      send_paced(ACT_READ, page_base(NUM_PAGES_DEF - 1), '0);

      write_first_usable('0);
      send_paced(ACT_FREE, '0, '0);
      send_paced(ACT_READ, 25'h0FFFFFF, '0);
      send_paced(ACT_ALLOC, '1, '1);                      // unused fields all ones

      // ---- saturation: push a page, pin its count at the top, hand it out ----
      send_paced(ACT_FREE, page_base(SAT_PAGE), '0);
      repeat (258) send_paced(ACT_ADD, page_base(SAT_PAGE), 8'hFF);
      send_paced(ACT_ALLOC, '0, '0);                      // saturated allocate
      send_paced(ACT_FREE, page_base(SAT_PAGE), '0);

      // ---- random traffic under several first-usable settings ----
      for (int chunk = 0; chunk < 4; chunk++) begin
         case (chunk)
            0: fup = '0;
            1: fup = CFG_W'($urandom_range(1, NUM_PAGES_DEF - 2));
            2: fup = CFG_W'($urandom_range(0, 255));
            default: fup = '1;
         endcase
         write_first_usable(fup);
         // long receiver hold-off while the sender keeps offering words
         if (chunk == 1) stall_hold_request = 1'b1;
         repeat (265) begin
            random_word(act, addr, addn);
            send_paced(act, addr, addn);
         end
      end

      drain_pipeline();
      repeat (16) @(posedge clock);
      if (pool.mismatch_count == 0 && pool.pending() == 0)
         $display("** refcounted_page_allocator: PASSED **");
      else
         $display("** refcounted_page_allocator: FAILED **");
      $finish;
   end

endmodule

// ----- refcounted_page_allocator.f -----
+incdir+rtl/core
rtl/core/rpa_pkg.sv
rtl/core/rpa_ram.sv
rtl/core/refcounted_page_allocator.sv
tb/refcounted_page_allocator_test.sv
